// ----- rtl/pcc_pkg.sv -----
package pcc_pkg;

    // Field widths of the request and result channels.
    localparam int COORD_W   = 32;
    localparam int QUAT_W    = 16;
    localparam int INDEX_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;

    // Register widths.
    localparam int CUBE_W  = 31;
    localparam int HOLE_W  = 31;
    localparam int CLEAR_W = 16;
    localparam int COUNT_W = 10;
    localparam logic [CLEAR_W-1:0] CLEAR_RESET = CLEAR_W'(7);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CUBE_HALF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_RADIUS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd3;

    // Opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Datapath widths.
    localparam int QP_W  = 32;   // product of two quaternion parts
    localparam int ROT_W = 34;   // rotation entry, Q.28
    localparam int PH_W  = 50;   // entry times high half of a coordinate
    localparam int PL_W  = 51;   // entry times low half of a coordinate
    localparam int SH_W  = 52;
    localparam int SL_W  = 53;
    localparam int TOT_W = 70;
    localparam int ROT_OUT_W = 41;
    localparam int WORLD_W = 42;
    localparam int LIM_W = 32;
    localparam int SQ_W  = 64;

    localparam int ONE_Q28  = 1 << 28;
    localparam int HALF_Q28 = 1 << 27;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QPROD,
        ST_RMAT,
        ST_RUN,
        ST_DRAIN,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic capture;
        logic issue;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic issue_last;
        logic pipe_busy;
    } status_t;

endpackage

// ----- rtl/pcc_in_if.sv -----
interface pcc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [pcc_pkg::INDEX_W-1:0]        sample_index;
    logic signed [pcc_pkg::COORD_W-1:0] sample_x;
    logic signed [pcc_pkg::COORD_W-1:0] sample_y;
    logic signed [pcc_pkg::COORD_W-1:0] sample_z;
    logic signed [pcc_pkg::COORD_W-1:0] pos_x;
    logic signed [pcc_pkg::COORD_W-1:0] pos_y;
    logic signed [pcc_pkg::COORD_W-1:0] pos_z;
    logic signed [pcc_pkg::QUAT_W-1:0]  quat_w;
    logic signed [pcc_pkg::QUAT_W-1:0]  quat_x;
    logic signed [pcc_pkg::QUAT_W-1:0]  quat_y;
    logic signed [pcc_pkg::QUAT_W-1:0]  quat_z;

    modport source (
        output valid, opcode, sample_index, sample_x, sample_y, sample_z,
               pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, sample_index, sample_x, sample_y, sample_z,
               pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

// ----- rtl/pcc_out_if.sv -----
interface pcc_out_if;
    logic valid;
    logic ready;
    logic collision_free;

    modport source (output valid, collision_free, input ready);
    modport sink (input valid, collision_free, output ready);
endinterface

// ----- rtl/pcc_ram.sv -----
module pcc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 512
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/pcc_ctrl.sv -----
module pcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_opcode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pcc_pkg::cmd_t     cmd,
    input  pcc_pkg::status_t  status
);
    pcc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;

    assign accept = in_valid && (state_reg == pcc_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcc_pkg::ST_IDLE:
            begin
                if (accept && (in_opcode == pcc_pkg::OP_CHECK))
                begin
                    state_next = pcc_pkg::ST_QPROD;
                end
            end
            pcc_pkg::ST_QPROD:
            begin
                state_next = pcc_pkg::ST_RMAT;
            end
            pcc_pkg::ST_RMAT:
            begin
                state_next = status.count_zero ? pcc_pkg::ST_DRAIN : pcc_pkg::ST_RUN;
            end
            pcc_pkg::ST_RUN:
            begin
                if (status.issue_last)
                begin
                    state_next = pcc_pkg::ST_DRAIN;
                end
            end
            pcc_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = pcc_pkg::ST_PUBLISH;
                end
            end
            pcc_pkg::ST_PUBLISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = pcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == pcc_pkg::ST_IDLE);
        cmd.load_wr = accept && (in_opcode == pcc_pkg::OP_LOAD);
        cmd.capture = accept && (in_opcode == pcc_pkg::OP_CHECK);
        cmd.issue   = (state_reg == pcc_pkg::ST_RUN);
        cmd.publish = (state_reg == pcc_pkg::ST_PUBLISH) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ----- rtl/pcc_datapath.sv -----
module pcc_datapath #(
    parameter int MAX_SAMPLES = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [pcc_pkg::INDEX_W-1:0]          sample_index,
    input  logic signed [pcc_pkg::COORD_W-1:0]   sample_x,
    input  logic signed [pcc_pkg::COORD_W-1:0]   sample_y,
    input  logic signed [pcc_pkg::COORD_W-1:0]   sample_z,
    input  logic signed [pcc_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [pcc_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [pcc_pkg::COORD_W-1:0]   pos_z,
    input  logic signed [pcc_pkg::QUAT_W-1:0]    quat_w,
    input  logic signed [pcc_pkg::QUAT_W-1:0]    quat_x,
    input  logic signed [pcc_pkg::QUAT_W-1:0]    quat_y,
    input  logic signed [pcc_pkg::QUAT_W-1:0]    quat_z,
    input  pcc_pkg::cmd_t                        cmd,
    output pcc_pkg::status_t                     status,
    output logic                                 collision_free
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = 3 * pcc_pkg::COORD_W;
    localparam int XW = pcc_pkg::INDEX_W + AW;

    // Configuration registers.
    logic [pcc_pkg::CUBE_W-1:0]  cube_half_reg;
    logic [pcc_pkg::HOLE_W-1:0]  hole_radius_reg;
    logic [pcc_pkg::CLEAR_W-1:0] clearance_reg;
    logic [pcc_pkg::COUNT_W-1:0] sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_half_reg    <= '0;
            hole_radius_reg  <= '0;
            clearance_reg    <= pcc_pkg::CLEAR_RESET;
            sample_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcc_pkg::REG_CUBE_HALF:    cube_half_reg    <= cfg_data[pcc_pkg::CUBE_W-1:0];
                pcc_pkg::REG_HOLE_RADIUS:  hole_radius_reg  <= cfg_data[pcc_pkg::HOLE_W-1:0];
                pcc_pkg::REG_CLEARANCE:    clearance_reg    <= cfg_data[pcc_pkg::CLEAR_W-1:0];
                pcc_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[pcc_pkg::COUNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Point store and sweep counter.
    logic [XW-1:0]    index_ext;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PW-1:0]    rd_data;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    n_eff;

    assign index_ext = XW'(sample_index);
    assign wr_en     = cmd.load_wr && (32'(index_ext) < 32'(MAX_SAMPLES));
    assign wr_addr   = index_ext[AW-1:0];

    pcc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({sample_z, sample_y, sample_x}),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign n_eff = (32'(sample_count_reg) > 32'(MAX_SAMPLES)) ?
                   CW'(MAX_SAMPLES) : CW'(sample_count_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.capture)
        begin
            cnt_next = '0;
        end
        else if (cmd.issue)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Pose capture and rotation matrix set-up.
    logic signed [pcc_pkg::COORD_W-1:0] pos_reg [3];
    logic signed [pcc_pkg::QUAT_W-1:0]  qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [pcc_pkg::QP_W-1:0]    xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [pcc_pkg::QP_W-1:0]    wx_reg, wy_reg, wz_reg;
    logic signed [pcc_pkg::ROT_W-1:0]   r_reg [3][3];
    logic [pcc_pkg::LIM_W-1:0]          cube_lim_reg, hole_lim_reg;
    logic [pcc_pkg::SQ_W-1:0]           hole_sq_reg;

    function automatic logic signed [pcc_pkg::ROT_W-1:0] diag_entry(
        input logic signed [pcc_pkg::QP_W-1:0] a,
        input logic signed [pcc_pkg::QP_W-1:0] b
    );
        logic signed [pcc_pkg::QP_W:0] s;
        s = (pcc_pkg::QP_W+1)'(a) + (pcc_pkg::QP_W+1)'(b);
        return pcc_pkg::ROT_W'(pcc_pkg::ONE_Q28) - (pcc_pkg::ROT_W'(s) <<< 1);
    endfunction

    function automatic logic signed [pcc_pkg::ROT_W-1:0] off_entry(
        input logic signed [pcc_pkg::QP_W-1:0] a,
        input logic signed [pcc_pkg::QP_W-1:0] b,
        input logic                            subtract
    );
        logic signed [pcc_pkg::QP_W:0] s;
        s = subtract ? (pcc_pkg::QP_W+1)'(a) - (pcc_pkg::QP_W+1)'(b)
                     : (pcc_pkg::QP_W+1)'(a) + (pcc_pkg::QP_W+1)'(b);
        return pcc_pkg::ROT_W'(s) <<< 1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            qw_reg     <= quat_w;
            qx_reg     <= quat_x;
            qy_reg     <= quat_y;
            qz_reg     <= quat_z;
        end
        // Quaternion products and bound limits, taken in the cycle after capture.
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        xz_reg <= qx_reg * qz_reg;
        yz_reg <= qy_reg * qz_reg;
        wx_reg <= qw_reg * qx_reg;
        wy_reg <= qw_reg * qy_reg;
        wz_reg <= qw_reg * qz_reg;
        cube_lim_reg <= pcc_pkg::LIM_W'(cube_half_reg) + pcc_pkg::LIM_W'(clearance_reg);
        hole_lim_reg <= pcc_pkg::LIM_W'(hole_radius_reg) + pcc_pkg::LIM_W'(clearance_reg);
        // Matrix entries and squared hole limit, taken in the cycle after the products.
        hole_sq_reg  <= pcc_pkg::SQ_W'(hole_lim_reg) * pcc_pkg::SQ_W'(hole_lim_reg);
        r_reg[0][0]  <= diag_entry(yy_reg, zz_reg);
        r_reg[0][1]  <= off_entry(xy_reg, wz_reg, 1'b1);
        r_reg[0][2]  <= off_entry(xz_reg, wy_reg, 1'b0);
        r_reg[1][0]  <= off_entry(xy_reg, wz_reg, 1'b0);
        r_reg[1][1]  <= diag_entry(xx_reg, zz_reg);
        r_reg[1][2]  <= off_entry(yz_reg, wx_reg, 1'b1);
        r_reg[2][0]  <= off_entry(xz_reg, wy_reg, 1'b1);
        r_reg[2][1]  <= off_entry(yz_reg, wx_reg, 1'b0);
        r_reg[2][2]  <= diag_entry(xx_reg, yy_reg);
    end

    // Point pipeline: products, partial sums, rounding, translation,
    // cube test, squares, hole test.
    logic [7:1] v_reg;
    logic signed [pcc_pkg::PH_W-1:0]  ph_reg [3][3];
    logic signed [pcc_pkg::PL_W-1:0]  pl_reg [3][3];
    logic signed [pcc_pkg::SH_W-1:0]  sh_reg [3];
    logic signed [pcc_pkg::SL_W-1:0]  sl_reg [3];
    logic signed [pcc_pkg::ROT_OUT_W-1:0] t_reg [3];
    logic signed [pcc_pkg::WORLD_W-1:0]   w_reg [3];
    logic [pcc_pkg::LIM_W-1:0]        ax_reg, ay_reg;
    logic                             in6_reg, in7_reg;
    logic [pcc_pkg::SQ_W-1:0]         sqx_reg, sqy_reg;
    logic                             free_reg, result_reg;

    logic signed [pcc_pkg::COORD_W-1:0]   p [3];
    logic signed [pcc_pkg::QUAT_W-1:0]    p_hi [3];
    logic signed [pcc_pkg::QUAT_W:0]      p_lo [3];
    logic signed [pcc_pkg::TOT_W-1:0]     tot [3];
    logic [pcc_pkg::WORLD_W-1:0]          mag [3];
    logic                                 in_cube;
    logic                                 hit;

    always_comb
    begin
        p[0] = rd_data[pcc_pkg::COORD_W-1:0];
        p[1] = rd_data[2*pcc_pkg::COORD_W-1:pcc_pkg::COORD_W];
        p[2] = rd_data[3*pcc_pkg::COORD_W-1:2*pcc_pkg::COORD_W];
        for (int i = 0; i < 3; i++)
        begin
            p_hi[i] = p[i][pcc_pkg::COORD_W-1:pcc_pkg::QUAT_W];
            p_lo[i] = {1'b0, p[i][pcc_pkg::QUAT_W-1:0]};
        end
        in_cube = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            tot[j] = (pcc_pkg::TOT_W'(sh_reg[j]) <<< 16) + pcc_pkg::TOT_W'(sl_reg[j]);
            mag[j] = w_reg[j][pcc_pkg::WORLD_W-1] ? pcc_pkg::WORLD_W'(-w_reg[j])
                                                   : pcc_pkg::WORLD_W'(w_reg[j]);
            if (mag[j] > pcc_pkg::WORLD_W'(cube_lim_reg))
            begin
                in_cube = 1'b0;
            end
        end
        hit = in7_reg && (((pcc_pkg::SQ_W+1)'(sqx_reg) + (pcc_pkg::SQ_W+1)'(sqy_reg))
                          > (pcc_pkg::SQ_W+1)'(hole_sq_reg));
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ph_reg[j][i] <= r_reg[j][i] * p_hi[i];
                pl_reg[j][i] <= r_reg[j][i] * p_lo[i];
            end
            sh_reg[j] <= pcc_pkg::SH_W'(ph_reg[j][0]) + pcc_pkg::SH_W'(ph_reg[j][1])
                       + pcc_pkg::SH_W'(ph_reg[j][2]);
            sl_reg[j] <= pcc_pkg::SL_W'(pl_reg[j][0]) + pcc_pkg::SL_W'(pl_reg[j][1])
                       + pcc_pkg::SL_W'(pl_reg[j][2]) + pcc_pkg::SL_W'(pcc_pkg::HALF_Q28);
            t_reg[j]  <= tot[j][pcc_pkg::ROT_OUT_W+27:28];
            w_reg[j]  <= pcc_pkg::WORLD_W'(t_reg[j]) + pcc_pkg::WORLD_W'(pos_reg[j]);
        end
        ax_reg  <= mag[0][pcc_pkg::LIM_W-1:0];
        ay_reg  <= mag[1][pcc_pkg::LIM_W-1:0];
        in6_reg <= in_cube;
        sqx_reg <= pcc_pkg::SQ_W'(ax_reg) * pcc_pkg::SQ_W'(ax_reg);
        sqy_reg <= pcc_pkg::SQ_W'(ay_reg) * pcc_pkg::SQ_W'(ay_reg);
        in7_reg <= in6_reg;
        if (cmd.publish)
        begin
            result_reg <= free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            free_reg <= 1'b1;
        end
        else
        begin
            v_reg <= {v_reg[6:1], cmd.issue};
            if (cmd.capture)
            begin
                free_reg <= 1'b1;
            end
            else if (v_reg[7] && hit)
            begin
                free_reg <= 1'b0;
            end
        end
    end

    assign status.count_zero = (n_eff == '0);
    assign status.issue_last = (cnt_reg == (n_eff - CW'(1)));
    assign status.pipe_busy  = |v_reg;
    assign collision_free    = result_reg;
endmodule

// ----- rtl/pose_collision_check.sv -----
// Pose collision check. Load requests (opcode 0) store one body-frame
// sample point in slot sample_index and give no result; a slot at or beyond
// MAX_SAMPLES is ignored. A check request (opcode 1) carries a pose, a Q16.16
// translation and a Q2.14 quaternion that is used as given, without
// normalisation. The block builds the rotation matrix, moves every point in
// slots 0 to N-1, N being sample_count capped at MAX_SAMPLES, into the world
// frame (exact products, rounded half up to Q16.16) and returns one
// collision_free flag: 0 when some point lies inside the cube of half edge
// cube_half + clearance and outside the z hole of radius hole_radius +
// clearance, 1 otherwise. A check sets up the matrix first, then sends one
// point per cycle through the single read port of the point store, and
// finishes when the last point has left the transform and test pipeline.
// Requests are taken only while no check is in flight; a finished flag waits
// in the output register, so the next request is taken even when the result
// has not yet been collected. Slots that were never loaded must not be
// covered by sample_count.
module pose_collision_check #(
    parameter int MAX_SAMPLES = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pcc_in_if.sink                            in_ch,
    pcc_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    pcc_pkg::cmd_t    cmd;
    pcc_pkg::status_t status;

    // The controller sequences set-up, the point sweep, the pipeline drain
    // and the hand-over of the result.
    pcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the registers, the point store and the pipeline.
    pcc_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_index   (in_ch.sample_index),
        .sample_x       (in_ch.sample_x),
        .sample_y       (in_ch.sample_y),
        .sample_z       (in_ch.sample_z),
        .pos_x          (in_ch.pos_x),
        .pos_y          (in_ch.pos_y),
        .pos_z          (in_ch.pos_z),
        .quat_w         (in_ch.quat_w),
        .quat_x         (in_ch.quat_x),
        .quat_y         (in_ch.quat_y),
        .quat_z         (in_ch.quat_z),
        .cmd            (cmd),
        .status         (status),
        .collision_free (out_ch.collision_free)
    );
endmodule
